### rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;

    localparam int SENSOR_COUNT = 4;
    localparam int READING_W    = 12;
    localparam int QUOT_W       = 12;
    localparam int STEP_W       = $clog2(QUOT_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;      // write row, bump count and slot, clear sums
        logic rd_en;     // read history row and advance pointer
        logic div_step;  // one restoring division step on every lane
        logic out_load;  // move quotients into the output register
    } cmd_t;

    typedef struct packed {
        logic rd_last;
        logic div_last;
    } status_t;

endpackage
`default_nettype wire

### rtl/sha_controller.sv
`default_nettype none
module sha_controller (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire              m_ready,
    input  sha_pkg::status_t status,
    output sha_pkg::cmd_t    cmd
);

    sha_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sha_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sha_pkg::ST_SUM;
                end
            end
            sha_pkg::ST_SUM: begin
                cmd.rd_en = 1'b1;
                if (status.rd_last) begin
                    state_next = sha_pkg::ST_DRAIN;
                end
            end
            // last read data lands in the sums
            sha_pkg::ST_DRAIN: begin
                state_next = sha_pkg::ST_DIV;
            end
            sha_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = sha_pkg::ST_DONE;
                end
            end
            sha_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = sha_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

### rtl/sha_datapath.sv
`default_nettype none
module sha_datapath #(
    parameter int HISTORY_DEPTH = 8
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  sha_pkg::cmd_t                   cmd,
    output sha_pkg::status_t                status,
    input  wire  [sha_pkg::READING_W-1:0]   s_reading_left,
    input  wire  [sha_pkg::READING_W-1:0]   s_reading_front_a,
    input  wire  [sha_pkg::READING_W-1:0]   s_reading_front_b,
    input  wire  [sha_pkg::READING_W-1:0]   s_reading_right,
    output logic [sha_pkg::QUOT_W-1:0]      m_average_left,
    output logic [sha_pkg::QUOT_W-1:0]      m_average_front_a,
    output logic [sha_pkg::QUOT_W-1:0]      m_average_front_b,
    output logic [sha_pkg::QUOT_W-1:0]      m_average_right
);

    localparam int ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = sha_pkg::READING_W + CNT_W;
    localparam int ROW_W  = sha_pkg::SENSOR_COUNT * sha_pkg::READING_W;
    localparam int LANES  = sha_pkg::SENSOR_COUNT;
    localparam int RW     = sha_pkg::READING_W;
    localparam int QW     = sha_pkg::QUOT_W;

    logic [ROW_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [sha_pkg::STEP_W-1:0] step_reg;

    logic [SUM_W-1:0] acc_reg  [LANES];
    logic [QW-1:0]    quot_reg [LANES];
    logic [QW-1:0]    out_reg  [LANES];

    logic [ROW_W-1:0] wr_row;
    logic [SUM_W-1:0] divisor;

    assign wr_row = {s_reading_right, s_reading_front_b, s_reading_front_a, s_reading_left};

    always_comb begin
        slot_next = (slot_reg == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        count_next = (count_reg == CNT_W'(HISTORY_DEPTH)) ? count_reg : count_reg + 1'b1;
        divisor = SUM_W'(count_reg) << step_reg;
        status.rd_last  = (CNT_W'(rd_ptr_reg) + 1'b1) == count_reg;
        status.div_last = (step_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hist_mem[slot_reg] <= wr_row;
        end
        rd_data_reg <= hist_mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.load) begin
                slot_reg  <= slot_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_ptr_reg <= '0;
            step_reg   <= sha_pkg::STEP_W'(QW - 1);
        end else begin
            if (cmd.rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (cmd.div_step) begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // per-lane accumulate, then restoring divide by the stored count in place
    always_ff @(posedge aclk) begin
        for (int s = 0; s < LANES; s++) begin
            if (cmd.load) begin
                acc_reg[s] <= '0;
            end else if (rd_valid_reg) begin
                acc_reg[s] <= acc_reg[s] + SUM_W'(rd_data_reg[s*RW +: RW]);
            end else if (cmd.div_step) begin
                if (acc_reg[s] >= divisor) begin
                    acc_reg[s]  <= acc_reg[s] - divisor;
                    quot_reg[s] <= {quot_reg[s][QW-2:0], 1'b1};
                end else begin
                    quot_reg[s] <= {quot_reg[s][QW-2:0], 1'b0};
                end
            end
            if (cmd.out_load) begin
                out_reg[s] <= quot_reg[s];
            end
        end
    end

    assign m_average_left    = out_reg[0];
    assign m_average_front_a = out_reg[1];
    assign m_average_front_b = out_reg[2];
    assign m_average_right   = out_reg[3];

endmodule
`default_nettype wire

### rtl/sensor_history_average_core.sv
// channel | valid   | ready   | payload
// input   | s_valid | s_ready | s_reading_left, s_reading_front_a, s_reading_front_b,
//         |         |         | s_reading_right (12 bit each)
// result  | m_valid | m_ready | m_average_left, m_average_front_a, m_average_front_b,
//         |         |         | m_average_right (12 bit each)
//
// each item passes from accept to the next accept through one read per stored row
// of the history memory (separate write and read ports), a drain state,
// a 12-step restoring divide per sensor and one output load
// aresetn clears count, write slot and handshake state; history is not cleared
// a waiting result holds the output register; the next item is taken meanwhile
`default_nettype none
module sensor_history_average_core #(
    parameter int HISTORY_DEPTH = 8
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [sha_pkg::READING_W-1:0] s_reading_left,
    input  wire  [sha_pkg::READING_W-1:0] s_reading_front_a,
    input  wire  [sha_pkg::READING_W-1:0] s_reading_front_b,
    input  wire  [sha_pkg::READING_W-1:0] s_reading_right,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [sha_pkg::QUOT_W-1:0]    m_average_left,
    output logic [sha_pkg::QUOT_W-1:0]    m_average_front_a,
    output logic [sha_pkg::QUOT_W-1:0]    m_average_front_b,
    output logic [sha_pkg::QUOT_W-1:0]    m_average_right
);

    sha_pkg::cmd_t    cmd;
    sha_pkg::status_t status;

    sha_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sha_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_reading_left    (s_reading_left),
        .s_reading_front_a (s_reading_front_a),
        .s_reading_front_b (s_reading_front_b),
        .s_reading_right   (s_reading_right),
        .m_average_left    (m_average_left),
        .m_average_front_a (m_average_front_a),
        .m_average_front_b (m_average_front_b),
        .m_average_right   (m_average_right)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten before it was taken");

    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && cmd.div_step) && !(cmd.load && cmd.out_load))
        else $error("datapath commands overlap");
`endif

endmodule
`default_nettype wire
